FILE: sv/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg: shared types and constants of the LIF neuron with delay ring
// Item layouts for the input and result channels, register indexes and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package lif_pkg;

  // Default number of delay slots in the ring.
  localparam int RING_SLOTS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_POTENTIAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_STEPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_IN_USE     = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [15:0]        DECAY_FACTOR_RST     = 16'd65519;
  localparam logic [23:0]        INPUT_GAIN_RST       = 24'd6554;
  localparam logic signed [31:0] THRESHOLD_RST        = 32'sd1310720;
  localparam logic signed [31:0] RESET_POTENTIAL_RST  = 32'sd0;
  localparam logic [9:0]         REFRACTORY_STEPS_RST = 10'd20;
  localparam logic [4:0]         DELAY_IN_USE_RST     = 5'd15;

  // Limits of a signed 32-bit Q16.16 value.
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // One time step presented to the neuron.
  typedef struct packed {
    logic signed [31:0] ext_current;
    logic signed [31:0] spike_weight;
    logic               spike_in;
  } in_item_t;

  // Neuron state reported after one time step.
  typedef struct packed {
    logic signed [31:0] membrane_potential;
    logic               spike_out;
    logic               refractory;
    logic [31:0]        spike_total;
    logic [31:0]        step_index;
  } out_item_t;

endpackage

FILE: sv/lif_neuron_with_delay_ring.sv
// ----------------------------------------------------------------------------
// lif_neuron_with_delay_ring: leaky integrate-and-fire neuron with spike delay
// One item per time step. Incoming spike weights accumulate in a ring of delay
// slots held in a synchronous memory; the neuron delivers the slot it reaches,
// leaks, integrates the scaled current and fires at the threshold.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, stage one and the output register; a result
// enters the output register when stage one moves on, which out_stall can hold.
// Throughput: one item per cycle while the output is not stalled, set by the
// combinational potential update (decay multiply, three-term add, saturate,
// threshold compare) and by one ring read and one ring write per cycle.
// Reset: clears the neuron state and loads the register defaults; per-slot
// valid bits make the whole ring read as zero at once, with no clearing pass.
module lif_neuron_with_delay_ring
  import lif_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RING_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  // Saturate an exact sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'(Q_MAX);
    lo = 42'(Q_MIN);
    if (v > hi) begin
      sat32 = Q_MAX;
    end else if (v < lo) begin
      sat32 = Q_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Configuration registers.
  logic [15:0]        decay_factor;
  logic [23:0]        input_gain;
  logic signed [31:0] threshold;
  logic signed [31:0] reset_potential;
  logic [9:0]         refractory_steps;
  logic [4:0]         delay_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor     <= DECAY_FACTOR_RST;
      input_gain       <= INPUT_GAIN_RST;
      threshold        <= THRESHOLD_RST;
      reset_potential  <= RESET_POTENTIAL_RST;
      refractory_steps <= REFRACTORY_STEPS_RST;
      delay_in_use     <= DELAY_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECAY_FACTOR:     decay_factor     <= cfg_data[15:0];
        CFG_INPUT_GAIN:       input_gain       <= cfg_data[23:0];
        CFG_THRESHOLD:        threshold        <= cfg_data;
        CFG_RESET_POTENTIAL:  reset_potential  <= cfg_data;
        CFG_REFRACTORY_STEPS: refractory_steps <= cfg_data[9:0];
        CFG_DELAY_IN_USE:     delay_in_use     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: stage one holds an accepted item and its ring read,
  // the output register holds the finished result.
  logic s1_valid;
  logic s1_move;
  logic in_fire;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_fire  = in_valid && !in_stall;

  // Front state: tick counter and slot pointer advance at acceptance.
  logic [31:0]       tick_count;
  logic [SLOT_W-1:0] slot_pointer;
  logic [SLOT_W-1:0] next_slot;
  logic [CMP_W-1:0]  slots_used;
  logic [CMP_W-1:0]  slot_inc;

  always_comb begin
    if (delay_in_use == 5'd0) begin
      slots_used = CMP_W'(1);
    end else if (CMP_W'(delay_in_use) > CMP_W'(RING_SLOTS)) begin
      slots_used = CMP_W'(RING_SLOTS);
    end else begin
      slots_used = CMP_W'(delay_in_use);
    end
    slot_inc = CMP_W'(slot_pointer) + CMP_W'(1);
    if (slot_inc >= slots_used) begin
      next_slot = '0;
    end else begin
      next_slot = slot_inc[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      slot_pointer <= '0;
    end else if (in_fire) begin
      tick_count   <= tick_count + 32'd1;
      slot_pointer <= next_slot;
    end
  end

  // The input drive term does not depend on neuron state, so its product
  // is formed on the way into stage one.
  logic signed [56:0] drive_prod;
  assign drive_prod = in_item.ext_current * $signed({1'b0, input_gain});

  // Stage one payload.
  logic signed [40:0] s1_drive;
  logic signed [31:0] s1_weight;
  logic               s1_spike;
  logic [SLOT_W-1:0]  s1_add_slot;
  logic [SLOT_W-1:0]  s1_take_slot;
  logic [31:0]        s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_drive     <= drive_prod[56:16];
      s1_weight    <= in_item.spike_weight;
      s1_spike     <= in_item.spike_in;
      s1_add_slot  <= slot_pointer;
      s1_take_slot <= next_slot;
      s1_step      <= tick_count + 32'd1;
    end
  end

  // Delay ring memory. It is correct for every slot except the one under the
  // slot pointer, whose live value sits in slot_carry; each item writes back
  // only the slot it added into, and the delivered slot is cleared by
  // zeroing the carry that follows it.
  logic signed [31:0] ring [RING_SLOTS];
  logic [RING_SLOTS-1:0] ring_live;
  logic signed [31:0] ring_rd;
  logic               ring_rd_live;
  logic               fwd_hit;
  logic signed [31:0] fwd_val;
  logic signed [31:0] add_val;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ring[s1_add_slot] <= add_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_live <= '0;
    end else if (s1_move) begin
      ring_live[s1_add_slot] <= 1'b1;
    end
  end

  // Read of the slot to deliver, with forwarding of the write at the same edge.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_rd      <= ring[next_slot];
      ring_rd_live <= ring_live[next_slot];
      fwd_hit      <= s1_move && (s1_add_slot == next_slot);
      fwd_val      <= add_val;
    end
  end

  // Neuron state.
  logic signed [31:0] potential_reg;
  logic [9:0]         refractory_left;
  logic [31:0]        fired_count;
  logic signed [31:0] slot_carry;

  logic signed [31:0] potential_next;
  logic [9:0]         refractory_next;
  logic [31:0]        fired_next;
  logic signed [31:0] carry_next;
  logic               fired;
  logic signed [31:0] take_val;
  logic signed [31:0] mem_val;
  logic signed [48:0] leak_prod;
  logic signed [41:0] sum;

  // Stage two: slot add, delivery and the membrane update.
  always_comb begin
    if (s1_spike) begin
      add_val = sat32(42'(slot_carry) + 42'(s1_weight));
    end else begin
      add_val = slot_carry;
    end

    if (fwd_hit) begin
      mem_val = fwd_val;
    end else if (ring_rd_live) begin
      mem_val = ring_rd;
    end else begin
      mem_val = '0;
    end
    take_val = (s1_take_slot == s1_add_slot) ? add_val : mem_val;

    leak_prod = potential_reg * $signed({1'b0, decay_factor});
    sum = 42'($signed(leak_prod[48:16])) + 42'(s1_drive) + 42'(take_val);

    potential_next  = potential_reg;
    refractory_next = refractory_left;
    fired_next      = fired_count;
    carry_next      = take_val;
    fired           = 1'b0;
    if (refractory_left != 10'd0) begin
      refractory_next = refractory_left - 10'd1;
      if (refractory_next == 10'd0) begin
        potential_next = reset_potential;
      end
    end else begin
      potential_next = sat32(sum);
      carry_next     = '0;
      if (potential_next >= threshold) begin
        fired           = 1'b1;
        refractory_next = refractory_steps;
        if (fired_count != 32'hFFFF_FFFF) begin
          fired_next = fired_count + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      potential_reg   <= '0;
      refractory_left <= '0;
      fired_count     <= '0;
      slot_carry      <= '0;
    end else if (s1_move) begin
      potential_reg   <= potential_next;
      refractory_left <= refractory_next;
      fired_count     <= fired_next;
      slot_carry      <= carry_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item.membrane_potential <= potential_next;
      out_item.spike_out          <= fired;
      out_item.refractory         <= (refractory_next != 10'd0);
      out_item.spike_total        <= fired_next;
      out_item.step_index         <= s1_step;
    end
  end

endmodule
